FILE: hdl/lookup_pixel_running_average_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the lookup pixel running average block
// ---------------------------------------------------------------------------
`ifndef LOOKUP_PIXEL_RUNNING_AVERAGE_ASSERT_SVH
`define LOOKUP_PIXEL_RUNNING_AVERAGE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LPRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define LPRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/lpra_pkg.sv
// ---------------------------------------------------------------------------
// lpra_pkg
// shared widths, codes and types of the lookup pixel running average block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpra_pkg;

   // default sizes of the stores
   localparam int LOOKUP_DEPTH_DEF = 16384;
   localparam int PIXEL_COUNT_DEF  = 16384;
   localparam int CHANNELS_DEF     = 4;

   // sample lanes carried by one request
   localparam int SAMPLE_FIELDS = 4;
   localparam int SAMPLE_SEL_W  = $clog2(SAMPLE_FIELDS);

   // field widths
   localparam int CMD_W = 2;
   localparam int IDX_W = 14;
   localparam int PIX_W = 14;
   localparam int RCH_W = 2;
   localparam int VAL_W = 16;

   // register widths and reset values
   localparam int LENGTH_CFG_W = 15;
   localparam int CHANS_CFG_W  = 3;
   localparam logic [LENGTH_CFG_W-1:0] LENGTH_RESET = 15'd16384;
   localparam logic [CHANS_CFG_W-1:0]  CHANS_RESET  = 3'd1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LENGTH_CFG_W;

   // stream packing
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;

   // divider: quotient always fits one value width
   localparam int PROD_W        = 2 * VAL_W;
   localparam int DIV_W         = VAL_W + 1;
   localparam int DIV_BITS_STEP = 2;
   localparam int DIV_CYCLES    = VAL_W / DIV_BITS_STEP;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_MAP  = 2'd1,
      CMD_READ = 2'd2
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOOKUP_LENGTH   = 1'b0,
      CSR_CHANNELS_IN_USE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DIV_W-1:0]  divisor;
   } div_request_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [VAL_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_status_type;

endpackage

`default_nettype wire

FILE: hdl/lpra_divider.sv
// ---------------------------------------------------------------------------
// lpra_divider
// iterative restoring divider, two quotient bits per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpra_divider
   import lpra_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire div_request_type div_req,
   output div_status_type       div_sts
);

   localparam int CNT_W = $clog2(DIV_CYCLES);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;

   logic [DIV_W:0]   trial;
   logic [DIV_W-1:0] part_rem;
   logic [VAL_W-1:0] part_quo;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      trial    = '0;
      part_rem = rem_ff;
      part_quo = quo_ff;
      if (div_req.start) begin
         // upper half is already below the divisor, so the quotient is one value wide
         rem_in  = DIV_W'(div_req.dividend[PROD_W-1:VAL_W]);
         quo_in  = div_req.dividend[VAL_W-1:0];
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_BITS_STEP; i++) begin
            trial    = {part_rem, part_quo[VAL_W-1]};
            part_quo = {part_quo[VAL_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_ff}) begin
               trial       = trial - {1'b0, dsr_ff};
               part_quo[0] = 1'b1;
            end
            part_rem = trial[DIV_W-1:0];
         end
         rem_in = part_rem;
         quo_in = part_quo;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_sts.busy      = busy_ff;
   assign div_sts.done      = done_ff;
   assign div_sts.quotient  = quo_ff;
   assign div_sts.remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hdl/lookup_pixel_running_average.sv
// ---------------------------------------------------------------------------
// lookup_pixel_running_average
// maps scanner sample sets to pixels via a lookup table and keeps a running
// average of every pixel over frames
// ---------------------------------------------------------------------------
// usage
//   req_* carries one command per transfer: load a lookup entry, map a sample
//   set to the pixel at the current lookup position, or read a pixel back
//   rsp_* returns exactly one result per command; rsp_tlast is frame complete
//   csr_* writes the lookup length and the channel count, only while idle:
//   that rule binds the user, as the block itself leaves it unenforced
// sequence
//   a load writes its lookup entry, a read issues a pixel read and takes the
//   data, an unused command goes straight to the result; a map command reads
//   the lookup entry, then per channel in use does a pixel read, the shared
//   multiplier, a divider start, the shared divider, which retires two
//   quotient bits a cycle, and the write-back
//   one command is in flight at a time; req_tready is high only when idle
// reset
//   lookup position returns to zero, length to 16384, channels to 1; the
//   lookup and pixel stores are not cleared and need no clearing pass
// back-pressure
//   a finished result waits in the rsp register; a new command may be taken
//   meanwhile, and its result waits until the previous one is transferred
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lookup_pixel_running_average_assert.svh"

module lookup_pixel_running_average
   import lpra_pkg::*;
#(
   parameter int LOOKUP_DEPTH = LOOKUP_DEPTH_DEF,
   parameter int PIXEL_COUNT  = PIXEL_COUNT_DEF,
   parameter int CHANNELS     = CHANNELS_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // index[13:0] pixel_target[27:14] read_channel[29:28] avg_count[45:30]
   // sample_ch0[61:46] sample_ch1[77:62] sample_ch2[93:78] sample_ch3[109:94]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // command[1:0]
   input  wire logic [CMD_W-1:0]       req_tuser,

   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // pixel_written[13:0] read_value[29:14]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast,

   // register write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // store geometry
   localparam int LA      = $clog2(LOOKUP_DEPTH);
   localparam int SA      = $clog2(CHANNELS * PIXEL_COUNT);
   localparam int LEN_W   = (LA + 1 > LENGTH_CFG_W) ? LA + 1 : LENGTH_CFG_W;
   localparam int CH_LIM  = (CHANNELS < SAMPLE_FIELDS) ? CHANNELS : SAMPLE_FIELDS;
   localparam int RSP_PAD = RSP_DATA_W - VAL_W - PIX_W;

   // request field offsets
   localparam int OFS_IDX = 0;
   localparam int OFS_TGT = OFS_IDX + IDX_W;
   localparam int OFS_RCH = OFS_TGT + PIX_W;
   localparam int OFS_AVG = OFS_RCH + RCH_W;
   localparam int OFS_SMP = OFS_AVG + VAL_W;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_LOAD      = 12'b0000_0000_0010,
      ST_RD_ISSUE  = 12'b0000_0000_0100,
      ST_RD_TAKE   = 12'b0000_0000_1000,
      ST_LUT_ISSUE = 12'b0000_0001_0000,
      ST_PIX_ISSUE = 12'b0000_0010_0000,
      ST_MUL       = 12'b0000_0100_0000,
      ST_DIV_GO    = 12'b0000_1000_0000,
      ST_DIV_WAIT  = 12'b0001_0000_0000,
      ST_WB        = 12'b0010_0000_0000,
      ST_ADVANCE   = 12'b0100_0000_0000,
      ST_FINISH    = 12'b1000_0000_0000
   } state_type;

   // control state
   state_type                state_ff, state_in;
   logic [LA-1:0]            pos_ff, pos_in;
   logic [SAMPLE_SEL_W-1:0]  ch_ff, ch_in;
   logic [LENGTH_CFG_W-1:0]  length_ff, length_in;
   logic [CHANS_CFG_W-1:0]   chans_ff, chans_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // captured request
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [PIX_W-1:0]         tgt_ff, tgt_in;
   logic [RCH_W-1:0]         rch_ff, rch_in;
   logic [VAL_W-1:0]         avg_ff, avg_in;
   logic [VAL_W-1:0]         sample_ff [SAMPLE_FIELDS];
   logic [VAL_W-1:0]         sample_in [SAMPLE_FIELDS];

   // working and result registers
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic                     res_frame_ff, res_frame_in;
   logic [PIX_W-1:0]         res_pixel_ff, res_pixel_in;
   logic [VAL_W-1:0]         res_value_ff, res_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [PIX_W-1:0]         rsp_pixel_ff, rsp_pixel_in;
   logic [VAL_W-1:0]         rsp_value_ff, rsp_value_in;

   // stores, read data registered
   logic [PIX_W-1:0]         lut_mem [LOOKUP_DEPTH];
   logic [VAL_W-1:0]         pix_mem [CHANNELS * PIXEL_COUNT];
   logic [PIX_W-1:0]         lut_rd_ff;
   logic [VAL_W-1:0]         pix_rd_ff;
   logic                     lut_wr_en, lut_rd_en, pix_wr_en, pix_rd_en;
   logic [LA-1:0]            lut_wr_addr, lut_rd_addr;
   logic [SA-1:0]            pix_wr_addr, pix_rd_addr;
   logic [VAL_W-1:0]         pix_wr_data;

   // derived values
   logic [LEN_W-1:0]         len_eff;
   logic [CHANS_CFG_W-1:0]   chans_eff;
   logic [LA-1:0]            pos_eff;
   logic [LEN_W-1:0]         pos_next;
   logic [SA-1:0]            map_addr, read_addr;
   logic                     pix_ok, read_ok, load_ok;
   logic [VAL_W-1:0]         old_eff;
   logic [DIV_W-1:0]         divisor, thr, thr_eff;
   logic [DIV_W-1:0]         rounded;
   logic [VAL_W-1:0]         avg_result;

   div_request_type          div_req;
   div_status_type           div_sts;

   lpra_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // zero length or channels act as one, capped at the table depth and lanes
   always_comb begin
      len_eff = LEN_W'(length_ff);
      if (len_eff == '0) begin
         len_eff = LEN_W'(1);
      end
      if (len_eff > LEN_W'(LOOKUP_DEPTH)) begin
         len_eff = LEN_W'(LOOKUP_DEPTH);
      end
      chans_eff = chans_ff;
      if (chans_eff == '0) begin
         chans_eff = CHANS_CFG_W'(1);
      end
      if (chans_eff > CHANS_CFG_W'(CH_LIM)) begin
         chans_eff = CHANS_CFG_W'(CH_LIM);
      end
   end

   assign pos_eff   = (LEN_W'(pos_ff) >= len_eff) ? '0 : pos_ff;
   assign pos_next  = LEN_W'(pos_ff) + LEN_W'(1);
   assign map_addr  = SA'(SA'(ch_ff) * SA'(PIXEL_COUNT)) + SA'(lut_rd_ff);
   assign read_addr = SA'(SA'(rch_ff) * SA'(PIXEL_COUNT)) + SA'(idx_ff);
   assign pix_ok    = 32'(lut_rd_ff) < 32'(PIXEL_COUNT);
   assign read_ok   = (32'(rch_ff) < 32'(CHANNELS)) && (32'(idx_ff) < 32'(PIXEL_COUNT));
   assign load_ok   = 32'(idx_ff) < 32'(LOOKUP_DEPTH);

   // zero count overwrites, so a pixel first mapped with count zero needs no clear
   assign old_eff   = (avg_ff == '0) ? '0 : pix_rd_ff;
   assign divisor   = DIV_W'(avg_ff) + DIV_W'(1);
   assign thr       = divisor >> 2;
   assign thr_eff   = (thr == '0) ? DIV_W'(1) : thr;

   // round up when the remainder passes the threshold, saturate at full scale
   assign rounded    = DIV_W'(div_sts.quotient)
                     + DIV_W'(div_sts.remainder > thr_eff);
   assign avg_result = rounded[VAL_W] ? {VAL_W{1'b1}} : rounded[VAL_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      ch_in        = ch_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      rch_in       = rch_ff;
      avg_in       = avg_ff;
      sample_in    = sample_ff;
      acc_in       = acc_ff;
      res_frame_in = res_frame_ff;
      res_pixel_in = res_pixel_ff;
      res_value_in = res_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      lut_wr_en    = 1'b0;
      lut_wr_addr  = LA'(idx_ff);
      lut_rd_en    = 1'b0;
      lut_rd_addr  = pos_eff;
      pix_wr_en    = 1'b0;
      pix_wr_addr  = map_addr;
      pix_wr_data  = avg_result;
      pix_rd_en    = 1'b0;
      pix_rd_addr  = map_addr;
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = divisor;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in       = req_tuser;
               idx_in       = req_tdata[OFS_IDX +: IDX_W];
               tgt_in       = req_tdata[OFS_TGT +: PIX_W];
               rch_in       = req_tdata[OFS_RCH +: RCH_W];
               avg_in       = req_tdata[OFS_AVG +: VAL_W];
               for (int i = 0; i < SAMPLE_FIELDS; i++) begin
                  sample_in[i] = req_tdata[OFS_SMP + i * VAL_W +: VAL_W];
               end
               ch_in        = '0;
               res_frame_in = 1'b0;
               res_pixel_in = '0;
               res_value_in = '0;
               priority case (req_tuser)
                  CMD_LOAD: state_in = ST_LOAD;
                  CMD_MAP:  state_in = ST_LUT_ISSUE;
                  CMD_READ: state_in = ST_RD_ISSUE;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_LOAD: begin
            lut_wr_en = load_ok;
            state_in  = ST_FINISH;
         end
         ST_RD_ISSUE: begin
            pix_rd_en   = read_ok;
            pix_rd_addr = read_addr;
            state_in    = ST_RD_TAKE;
         end
         ST_RD_TAKE: begin
            res_value_in = read_ok ? pix_rd_ff : '0;
            state_in     = ST_FINISH;
         end
         ST_LUT_ISSUE: begin
            // a stale position past a shortened length wraps first
            lut_rd_en = 1'b1;
            pos_in    = pos_eff;
            state_in  = ST_PIX_ISSUE;
         end
         ST_PIX_ISSUE: begin
            if (pix_ok) begin
               pix_rd_en = 1'b1;
               state_in  = ST_MUL;
            end else begin
               state_in  = ST_ADVANCE;
            end
         end
         ST_MUL: begin
            acc_in   = PROD_W'(old_eff) * PROD_W'(avg_ff) + PROD_W'(sample_ff[ch_ff]);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_sts.done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            pix_wr_en = 1'b1;
            if (CHANS_CFG_W'(ch_ff) + CHANS_CFG_W'(1) < chans_eff) begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_PIX_ISSUE;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            if (pos_next >= len_eff) begin
               pos_in       = '0;
               res_frame_in = 1'b1;
            end else begin
               pos_in       = LA'(pos_next);
            end
            res_pixel_in = lut_rd_ff;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = res_frame_ff;
               rsp_pixel_in = res_pixel_ff;
               rsp_value_in = res_value_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register writes; only while idle is the user's rule, unenforced here
   always_comb begin
      length_in = length_ff;
      chans_in  = chans_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOOKUP_LENGTH:   length_in = csr_data[LENGTH_CFG_W-1:0];
            CSR_CHANNELS_IN_USE: chans_in  = csr_data[CHANS_CFG_W-1:0];
            default:             length_in = length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         ch_ff        <= '0;
         length_ff    <= LENGTH_RESET;
         chans_ff     <= CHANS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ch_ff        <= ch_in;
         length_ff    <= length_in;
         chans_ff     <= chans_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      tgt_ff       <= tgt_in;
      rch_ff       <= rch_in;
      avg_ff       <= avg_in;
      sample_ff    <= sample_in;
      acc_ff       <= acc_in;
      res_frame_ff <= res_frame_in;
      res_pixel_ff <= res_pixel_in;
      res_value_ff <= res_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_value_ff <= rsp_value_in;
   end

   // lookup table store
   always_ff @(posedge clock) begin
      if (lut_wr_en) begin
         lut_mem[lut_wr_addr] <= tgt_ff;
      end
      if (lut_rd_en) begin
         lut_rd_ff <= lut_mem[lut_rd_addr];
      end
   end

   // pixel store, channel-major
   always_ff @(posedge clock) begin
      if (pix_wr_en) begin
         pix_mem[pix_wr_addr] <= pix_wr_data;
      end
      if (pix_rd_en) begin
         pix_rd_ff <= pix_mem[pix_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_value_ff, rsp_pixel_ff};

   // checks
   `LPRA_ASSERT_SAME(a_busy_blocks_req, clock, reset, div_sts.busy, !req_tready,
      "request taken while the divider is busy")
   `LPRA_ASSERT_SAME(a_done_when_waiting, clock, reset, div_sts.done,
      state_ff == ST_DIV_WAIT, "divider finished outside its wait state")
   `LPRA_ASSERT_SAME(a_write_in_channel, clock, reset, pix_wr_en,
      CHANS_CFG_W'(ch_ff) < chans_eff && cmd_ff == CMD_MAP,
      "pixel write beyond the channels in use")
   `LPRA_ASSERT_NEXT(a_frame_wraps, clock, reset,
      state_ff == ST_ADVANCE && res_frame_in, pos_ff == '0,
      "frame complete without the position wrapping")

endmodule

`default_nettype wire

FILE: bench/lookup_pixel_running_average_test.sv
// ---------------------------------------------------------------------------
// lookup_pixel_running_average_test
// self-checking bench: drives load, map, read and unused commands into the
// block, works out every response in a local model of the lookup table, the
// pixel store and the averaging, and compares each response field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lookup_pixel_running_average_test
   import lpra_pkg::*;
();

   // sizes of the default build
   localparam int LUT_ENTRIES = LOOKUP_DEPTH_DEF;
   localparam int PIXELS      = PIXEL_COUNT_DEF;
   localparam int LANES       = (CHANNELS_DEF < SAMPLE_FIELDS) ? CHANNELS_DEF : SAMPLE_FIELDS;

   // the command code the block leaves unused
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // run length and settling
   localparam int RANDOM_ITEMS = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 60;
   localparam int CYCLE_LIMIT = 1000000;

   // one request as it travels on req_tdata / req_tuser
   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [3:0][VAL_W-1:0]  samples;
      logic [VAL_W-1:0]       avg_count;
      logic [RCH_W-1:0]       read_channel;
      logic [PIX_W-1:0]       pixel_target;
      logic [IDX_W-1:0]       index;
   } lpra_req_type;

   // one response as it travels on rsp_tdata / rsp_tlast
   typedef struct packed {
      logic             frame_complete;
      logic [PIX_W-1:0] pixel_written;
      logic [VAL_W-1:0] read_value;
   } lpra_rsp_type;

   // clock, reset and the block's ports
   logic clock;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_LOOKUP_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // local copy of the block's state
   bit [PIX_W-1:0]         lut_model [0:LUT_ENTRIES-1];
   bit                     lut_loaded [0:LUT_ENTRIES-1];
   bit [VAL_W-1:0]         pixel_model [0:LANES*PIXELS-1];
   bit                     pixel_loaded [0:LANES*PIXELS-1];
   int unsigned            position_model = 0;
   logic [LENGTH_CFG_W-1:0] length_model = LENGTH_RESET;
   logic [CHANS_CFG_W-1:0]  chans_model = CHANS_RESET;

   // pixel store addresses written so far, for read-back
   int unsigned            written_q [$];
   // responses still owed by the block, oldest first
   lpra_rsp_type           pixel_rsp_q [$];
   // small pool of pixel targets so that pixels are hit again and averaged
   logic [PIX_W-1:0]       target_pool [$];

   int                     error_count = 0;
   int                     cycle_count = 0;
   int                     items_sent = 0;
   int                     burst_left = 0;
   int                     stall_mode = 0;
   int                     stall_mode_left = 0;
   lpra_rsp_type           rsp_head;

   lookup_pixel_running_average dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d responses outstanding", $time,
                  pixel_rsp_q.size());
         $display("lookup_pixel_running_average regression: fail");
         $finish;
      end
   end

   // receiver back-pressure in randomly chosen patterns
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_mode_left = $urandom_range(50, 300);
      end else begin
         stall_mode_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (cycle_count % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // response check: every response transfer against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_rsp_q.size() == 0) begin
            $display("%0t: response with none outstanding: tlast %0b tdata %h", $time,
                     rsp_tlast, rsp_tdata);
            error_count++;
         end else begin
            rsp_head = pixel_rsp_q.pop_front();
            if (rsp_tlast !== rsp_head.frame_complete) begin
               $display("%0t: frame_complete expected %0b actual %0b", $time,
                        rsp_head.frame_complete, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[13:0] !== rsp_head.pixel_written) begin
               $display("%0t: pixel_written expected %0d actual %0d", $time,
                        rsp_head.pixel_written, rsp_tdata[13:0]);
               error_count++;
            end
            if (rsp_tdata[29:14] !== rsp_head.read_value) begin
               $display("%0t: read_value expected %0d actual %0d", $time,
                        rsp_head.read_value, rsp_tdata[29:14]);
               error_count++;
            end
         end
      end
   end

   // length register as the block uses it: 0 acts as 1, clipped to the depth
   function automatic int unsigned eff_length();
      int unsigned n;
      n = length_model;
      if (n == 0) n = 1;
      if (n > LUT_ENTRIES) n = LUT_ENTRIES;
      return n;
   endfunction

   // channel register as the block uses it: 0 acts as 1, clipped to the lanes
   function automatic int unsigned eff_channels();
      int unsigned n;
      n = chans_model;
      if (n == 0) n = 1;
      if (n > LANES) n = LANES;
      return n;
   endfunction

   // cumulative mean: (old*k + s)/(k+1), rounded up past a quarter divisor
   function automatic logic [VAL_W-1:0] running_mean(input logic [VAL_W-1:0] old,
                                                     input logic [VAL_W-1:0] k,
                                                     input logic [VAL_W-1:0] s);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] thr;
      logic [63:0] q;
      n = 64'(old) * 64'(k) + 64'(s);
      d = 64'(k) + 64'd1;
      thr = d >> 2;
      if (thr == 64'd0) thr = 64'd1;
      q = n / d + (((n % d) > thr) ? 64'd1 : 64'd0);
      if (q > 64'hFFFF) q = 64'hFFFF;
      return q[VAL_W-1:0];
   endfunction

   // state update and response of one accepted command
   function automatic lpra_rsp_type apply_command(input lpra_req_type r);
      lpra_rsp_type o;
      int unsigned len;
      int unsigned pix;
      int unsigned addr;
      o = '0;
      case (r.command)
         CMD_LOAD: begin
            lut_model[r.index] = r.pixel_target;
            lut_loaded[r.index] = 1'b1;
         end
         CMD_MAP: begin
            len = eff_length();
            // position left beyond a shortened length wraps first
            if (position_model >= len) position_model = 0;
            pix = lut_model[position_model];
            for (int c = 0; c < eff_channels(); c++) begin
               addr = c * PIXELS + pix;
               pixel_model[addr] = running_mean(pixel_model[addr], r.avg_count, r.samples[c]);
               if (!pixel_loaded[addr]) begin
                  pixel_loaded[addr] = 1'b1;
                  written_q.push_back(addr);
               end
            end
            position_model++;
            if (position_model >= len) begin
               position_model = 0;
               o.frame_complete = 1'b1;
            end
            o.pixel_written = PIX_W'(pix);
         end
         CMD_READ: begin
            o.read_value = pixel_model[r.read_channel * PIXELS + r.index];
         end
         default: ;
      endcase
      return o;
   endfunction

   // every field random but the command; callers then set what matters for the command
   function automatic lpra_req_type random_req();
      lpra_req_type r;
      r.command = CMD_UNUSED;
      r.samples = {$urandom, $urandom};
      r.avg_count = VAL_W'($urandom);
      r.read_channel = RCH_W'($urandom);
      r.pixel_target = PIX_W'($urandom);
      r.index = IDX_W'($urandom);
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] pick_target();
      if ($urandom_range(0, 3) == 0) return PIX_W'($urandom);
      return target_pool[$urandom_range(0, target_pool.size() - 1)];
   endfunction

   // one request transfer; the sender goes in bursts with gaps between them
   task automatic send_req(input lpra_req_type r);
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, r.samples, r.avg_count, r.read_channel, r.pixel_target, r.index};
      req_tuser <= r.command;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transfer taken at this edge
      pixel_rsp_q.push_back(apply_command(r));
      items_sent++;
      burst_left--;
   endtask

   // stop sending and wait until the block has answered everything
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixel_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write; only called while the block is idle
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_LOOKUP_LENGTH:   length_model = value[LENGTH_CFG_W-1:0];
         CSR_CHANNELS_IN_USE: chans_model = value[CHANS_CFG_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_load(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] target);
      lpra_req_type r;
      r = random_req();
      r.command = CMD_LOAD;
      r.index = idx;
      r.pixel_target = target;
      send_req(r);
   endtask

   // map one sample set; loads the entry at the position first if it is
   // still empty, and falls back to k = 0 when a pixel has no value yet
   task automatic send_map(input logic [VAL_W-1:0] k, input logic [3:0][VAL_W-1:0] smp);
      lpra_req_type r;
      int unsigned pos;
      int unsigned pix;
      pos = (position_model >= eff_length()) ? 0 : position_model;
      if (!lut_loaded[pos]) send_load(IDX_W'(pos), pick_target());
      pix = lut_model[pos];
      for (int c = 0; c < eff_channels(); c++)
         if (!pixel_loaded[c * PIXELS + pix]) k = '0;
      r = random_req();
      r.command = CMD_MAP;
      r.avg_count = k;
      r.samples = smp;
      send_req(r);
   endtask

   // read back a pixel that holds a value
   task automatic send_read();
      lpra_req_type r;
      int unsigned addr;
      if (written_q.size() == 0) return;
      addr = written_q[$urandom_range(0, written_q.size() - 1)];
      r = random_req();
      r.command = CMD_READ;
      r.read_channel = RCH_W'(addr / PIXELS);
      r.index = IDX_W'(addr % PIXELS);
      send_req(r);
   endtask

   // reset register values, corner entries and a full-scale sample
   task automatic test_reset_defaults();
      send_load(14'd0, 14'h3FFF);
      send_load(14'h3FFF, 14'd0);
      send_map(16'd0, {4{16'hFFFF}});
      send_read();
      wait_idle();
   endtask

   // length 0 acts as 1, above the depth acts as the depth, and a
   // position beyond a shortened length wraps before use
   task automatic test_length_limits();
      write_csr(CSR_LOOKUP_LENGTH, 15'd0);
      send_map(16'd0, '0);
      send_map(16'd1, {$urandom, $urandom});
      wait_idle();
      write_csr(CSR_LOOKUP_LENGTH, 15'h7FFF);
      send_map(16'd0, {$urandom, $urandom});
      wait_idle();
      write_csr(CSR_LOOKUP_LENGTH, 15'd4);
      send_map(16'd0, {$urandom, $urandom});
      send_map(16'd0, {$urandom, $urandom});
      wait_idle();
      write_csr(CSR_LOOKUP_LENGTH, 15'd2);
      send_map(16'd0, {$urandom, $urandom});
      send_map(16'd0, {$urandom, $urandom});
      wait_idle();
   endtask

   // channel count 0 acts as 1, values past the lanes saturate
   task automatic test_channel_limits();
      write_csr(CSR_CHANNELS_IN_USE, 15'd0);
      send_map(16'd0, {$urandom, $urandom});
      wait_idle();
      write_csr(CSR_CHANNELS_IN_USE, 15'd7);
      send_map(16'd0, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000});
      send_read();
      send_read();
      wait_idle();
   endtask

   // one pixel on two channels averaged over a run of frames, rounding and full scale
   task automatic test_rounding();
      write_csr(CSR_LOOKUP_LENGTH, 15'd1);
      write_csr(CSR_CHANNELS_IN_USE, 15'd2);
      send_map(16'd0, {16'd0, 16'd0, 16'd200, 16'd100});
      send_map(16'd1, {16'd0, 16'd0, 16'd201, 16'd103});
      send_map(16'd2, {16'd0, 16'd0, 16'd207, 16'd99});
      send_map(16'd3, {16'd0, 16'd0, 16'd0, 16'd1000});
      send_map(16'hFFFF, {16'd0, 16'd0, 16'hFFFF, 16'hFFFF});
      send_read();
      wait_idle();
   endtask

   // unused command code answers with all fields zero
   task automatic test_unused_command();
      lpra_req_type r;
      r = random_req();
      r.command = CMD_UNUSED;
      send_req(r);
      send_read();
      wait_idle();
   endtask

   // phases of whole frames under random settings, with reads and noise
   task automatic test_random_traffic();
      int start;
      int unsigned len_cfg;
      int unsigned positions;
      int unsigned frames;
      lpra_req_type r;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // settings only change with the block idle
         wait_idle();
         case ($urandom_range(0, 7))
            0: len_cfg = 1;
            1: len_cfg = 0;
            2: len_cfg = $urandom_range(LUT_ENTRIES, 32767);
            default: len_cfg = $urandom_range(2, 12);
         endcase
         write_csr(CSR_LOOKUP_LENGTH, CSR_DATA_W'(len_cfg));
         write_csr(CSR_CHANNELS_IN_USE, CSR_DATA_W'($urandom_range(0, 7)));
         positions = (eff_length() > 12) ? $urandom_range(8, 24) : eff_length();
         // fresh lookup contents for short frames
         if (eff_length() <= 12)
            for (int i = 0; i < eff_length(); i++)
               if (!lut_loaded[i] || $urandom_range(0, 2) == 0)
                  send_load(IDX_W'(i), pick_target());
         frames = $urandom_range(1, 5);
         for (int f = 0; f < frames; f++) begin
            for (int p = 0; p < positions; p++) begin
               if ($urandom_range(0, 7) == 0) send_map(VAL_W'($urandom), {$urandom, $urandom});
               else send_map(VAL_W'(f), {$urandom, $urandom});
               if ($urandom_range(0, 5) == 0) send_read();
               case ($urandom_range(0, 29))
                  0: begin
                     r = random_req();
                     r.command = CMD_UNUSED;
                     send_req(r);
                  end
                  1: send_load(IDX_W'($urandom), PIX_W'($urandom));
                  default: ;
               endcase
            end
         end
      end
   endtask

   // test sequence
   initial begin
      for (int i = 0; i < 20; i++) target_pool.push_back(PIX_W'($urandom));
      target_pool.push_back(14'd0);
      target_pool.push_back(14'h3FFF);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_length_limits();
      test_channel_limits();
      test_rounding();
      test_unused_command();
      test_random_traffic();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("lookup_pixel_running_average regression: pass");
      else
         $display("lookup_pixel_running_average regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/lpra_pkg.sv
hdl/lpra_divider.sv
hdl/lookup_pixel_running_average.sv
bench/lookup_pixel_running_average_test.sv
